### hw/rtl/mke_pkg.sv
// Shared constants, types and the key profile weight table of the key estimator.
package mke_pkg;

  localparam int NUM_CLASSES      = 12;
  localparam int NOTE_W           = 7;
  localparam int ROOT_W           = 4;
  localparam int MODE_W           = 2;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int WEIGHT_FRAC_BITS = 14;
  localparam int WGT_W            = WEIGHT_FRAC_BITS + 2;
  localparam int BIT_CNT_W        = $clog2(WGT_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_MAJOR   = 2'd1,
    MODE_MINOR   = 2'd2
  } key_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DONE
  } mke_state_t;

  // Sequencing of the serial multiply-accumulate unit.
  typedef struct packed {
    logic active;     // a weight bit is processed this cycle
    logic first_bit;  // load a fresh operand and weight
    logic last_bit;   // sign bit of the weight: subtract
    logic last_term;  // twelfth product of a rating: hand out the sum
  } mac_ctl_t;

  // Profile weights in signed Q1.14: deviation from the mean, scaled by the root of
  // the summed squared deviation, rounded to nearest.
  function automatic logic signed [WGT_W-1:0] mke_weight(input logic minor,
                                                        input logic [ROOT_W-1:0] step);
    logic signed [WGT_W-1:0] w;
    case ({minor, step})
      5'd0:  w = WGT_W'(10737);
      5'd1:  w = WGT_W'(-4690);
      5'd2:  w = WGT_W'(-9);
      5'd3:  w = WGT_W'(-4315);
      5'd4:  w = WGT_W'(3361);
      5'd5:  w = WGT_W'(2275);
      5'd6:  w = WGT_W'(-3604);
      5'd7:  w = WGT_W'(6394);
      5'd8:  w = WGT_W'(-4091);
      5'd9:  w = WGT_W'(665);
      5'd10: w = WGT_W'(-4465);
      5'd11: w = WGT_W'(-2256);
      5'd16: w = WGT_W'(10733);
      5'd17: w = WGT_W'(-4215);
      5'd18: w = WGT_W'(-775);
      5'd19: w = WGT_W'(6842);
      5'd20: w = WGT_W'(-4542);
      5'd21: w = WGT_W'(-734);
      5'd22: w = WGT_W'(-4788);
      5'd23: w = WGT_W'(4262);
      5'd24: w = WGT_W'(1109);
      5'd25: w = WGT_W'(-4174);
      5'd26: w = WGT_W'(-1512);
      5'd27: w = WGT_W'(-2208);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/mke_serial_mac.sv
// Bit-serial multiply-accumulate unit: one weight bit per cycle, operand shifted along.
module mke_serial_mac #(
  parameter int COUNT_BITS = mke_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mke_pkg::mac_ctl_t                    ctl,
  input  logic signed [COUNT_BITS+4:0]         opnd,
  input  logic signed [mke_pkg::WGT_W-1:0]     weight,
  output logic signed [COUNT_BITS+mke_pkg::WGT_W+8:0] score
);
  import mke_pkg::*;

  localparam int VW    = COUNT_BITS + 5;
  localparam int ACC_W = COUNT_BITS + WGT_W + 9;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] vsh_r, vsh_nxt;
  logic        [WGT_W-1:0] wsh_r, wsh_nxt;
  logic signed [ACC_W-1:0] cur_v, term, sum;
  logic        [WGT_W-1:0] cur_w;

  always_comb begin
    cur_v = ctl.first_bit ? {{(ACC_W-VW){opnd[VW-1]}}, opnd} : vsh_r;
    cur_w = ctl.first_bit ? weight : wsh_r;
    term  = cur_w[0] ? cur_v : '0;
    // The top weight bit carries negative significance.
    sum   = ctl.last_bit ? (acc_r - term) : (acc_r + term);
    acc_nxt = acc_r;
    vsh_nxt = vsh_r;
    wsh_nxt = wsh_r;
    if (ctl.active) begin
      acc_nxt = (ctl.last_bit && ctl.last_term) ? '0 : sum;
      vsh_nxt = cur_v <<< 1;
      wsh_nxt = cur_w >> 1;
    end
  end

  assign score = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vsh_r <= vsh_nxt;
    wsh_r <= wsh_nxt;
  end

endmodule

### hw/rtl/musical_key_estimator_unit.sv
// Top level of the key estimator: pitch-class histogram, scan sequencer and key choice.
//
// A request is taken at a rising edge with start high and busy low; it carries one MIDI
// event (in_note_number, in_is_note_on, in_last). A note-on bumps the saturating counter
// of its pitch class in the cycle it is taken, so ordinary events go at one per cycle.
// A request with in_last set is counted first and then starts the analysis: the twelve
// counters rotate through a ring, and each of the 24 ratings (12 roots, major then
// minor) is a sum of 12 products formed by a bit-serial multiplier at one weight bit
// per cycle. Busy is high throughout the analysis and the closing state that follows it.
// In the first cycle with busy low again, out_valid pulses for one cycle with
// out_updated, out_root_class and out_key_mode; the receiver cannot stall, and a new
// request may be taken in that same cycle. Requests without in_last give no result.
// out_root_class and out_key_mode always show the current guess. If the histogram is
// empty or flat the guess is kept and out_updated is low. The histogram is cleared at
// the end of every analysis. Reset clears the histogram and sets the guess to root 0,
// mode unknown.
module musical_key_estimator_unit #(
  parameter int COUNT_BITS = mke_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mke_pkg::NOTE_W-1:0]   in_note_number,
  input  logic                         in_is_note_on,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic                         out_updated,
  output logic [mke_pkg::ROOT_W-1:0]   out_root_class,
  output logic [mke_pkg::MODE_W-1:0]   out_key_mode
);
  import mke_pkg::*;

  localparam int TOT_W = COUNT_BITS + 4;
  localparam int VW    = COUNT_BITS + 5;
  localparam int ACC_W = COUNT_BITS + WGT_W + 9;

  function automatic logic [ROOT_W-1:0] pitch_class(input logic [NOTE_W-1:0] note);
    logic [2:0] s;
    logic [1:0] m;
    // note = 4q + low, and 4 = 16 = 1 mod 3, so q mod 3 comes from its bit pairs.
    s = 3'(note[3:2]) + 3'(note[5:4]) + 3'(note[6]);
    if (s >= 3'd6) begin
      m = 2'(s - 3'd6);
    end else if (s >= 3'd3) begin
      m = 2'(s - 3'd3);
    end else begin
      m = s[1:0];
    end
    return {m, note[1:0]};
  endfunction

  mke_state_t state_r, state_nxt;
  logic [COUNT_BITS-1:0] cnt_r [NUM_CLASSES];
  logic [COUNT_BITS-1:0] cnt_nxt [NUM_CLASSES];
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [ROOT_W-1:0]     step_r, step_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic                  minor_r, minor_nxt;
  logic                  neq_r, neq_nxt;
  logic signed [ACC_W-1:0] best_r, best_nxt;
  logic [ROOT_W-1:0]     cand_root_r, cand_root_nxt;
  key_mode_t             cand_mode_r, cand_mode_nxt;
  logic [ROOT_W-1:0]     guess_root_r, guess_root_nxt;
  key_mode_t             guess_mode_r, guess_mode_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_upd_r, out_upd_nxt;

  logic                  accept;
  logic [ROOT_W-1:0]     pc;
  logic                  last_bit, last_term, rot2, upd;
  logic [VW-1:0]         v_head;
  logic signed [WGT_W-1:0] weight;
  logic signed [ACC_W-1:0] score;
  mac_ctl_t              mac_ctl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign pc     = pitch_class(in_note_number);

  assign last_bit  = (bit_r == BIT_CNT_W'(WGT_W - 1));
  assign last_term = (step_r == ROOT_W'(NUM_CLASSES - 1));
  assign rot2      = minor_r && last_term;

  // Rating operand of the class at the head of the ring: 12 * count - total.
  assign v_head = VW'({cnt_r[0], 3'b000}) + VW'({cnt_r[0], 2'b00}) - VW'(total_r);
  assign weight = mke_weight(minor_r, step_r);

  assign mac_ctl.active    = (state_r == ST_SCORE);
  assign mac_ctl.first_bit = (bit_r == '0);
  assign mac_ctl.last_bit  = last_bit;
  assign mac_ctl.last_term = last_term;

  mke_serial_mac #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .opnd   (v_head),
    .weight (weight),
    .score  (score)
  );

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    bit_nxt        = bit_r;
    step_nxt       = step_r;
    root_nxt       = root_r;
    minor_nxt      = minor_r;
    neq_nxt        = neq_r;
    best_nxt       = best_r;
    cand_root_nxt  = cand_root_r;
    cand_mode_nxt  = cand_mode_r;
    guess_root_nxt = guess_root_r;
    guess_mode_nxt = guess_mode_r;
    out_valid_nxt  = 1'b0;
    out_upd_nxt    = out_upd_r;
    upd            = (total_r != '0) && neq_r;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          for (int k = 0; k < NUM_CLASSES; k++) begin
            if (in_is_note_on && (pc == ROOT_W'(k)) && (cnt_r[k] != {COUNT_BITS{1'b1}})) begin
              cnt_nxt[k] = cnt_r[k] + 1'b1;
              total_nxt  = total_r + 1'b1;
            end
          end
          if (in_last) begin
            state_nxt     = ST_SCORE;
            bit_nxt       = '0;
            step_nxt      = '0;
            root_nxt      = '0;
            minor_nxt     = 1'b0;
            neq_nxt       = 1'b0;
            best_nxt      = '0;
            cand_root_nxt = '0;
            cand_mode_nxt = MODE_UNKNOWN;
          end
        end
      end

      ST_SCORE: begin
        // The first major pass sees every adjacent pair of the ring once.
        if ((root_r == '0) && !minor_r && (bit_r == '0) && (cnt_r[0] != cnt_r[1])) begin
          neq_nxt = 1'b1;
        end
        bit_nxt = last_bit ? '0 : bit_r + 1'b1;
        if (last_bit) begin
          // After the minor pass the ring moves two places to bring up the next root.
          for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_nxt[k] = rot2 ? cnt_r[(k + 2) % NUM_CLASSES] : cnt_r[(k + 1) % NUM_CLASSES];
          end
          step_nxt = last_term ? '0 : step_r + 1'b1;
          if (last_term) begin
            if (score > best_r) begin
              best_nxt      = score;
              cand_root_nxt = root_r;
              cand_mode_nxt = minor_r ? MODE_MINOR : MODE_MAJOR;
            end
            minor_nxt = !minor_r;
            if (minor_r) begin
              if (root_r == ROOT_W'(NUM_CLASSES - 1)) begin
                state_nxt = ST_DONE;
              end else begin
                root_nxt = root_r + 1'b1;
              end
            end
          end
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_upd_nxt   = upd;
        if (upd) begin
          guess_root_nxt = cand_root_r;
          guess_mode_nxt = cand_mode_r;
        end
        for (int k = 0; k < NUM_CLASSES; k++) begin
          cnt_nxt[k] = '0;
        end
        total_nxt = '0;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      bit_r        <= '0;
      step_r       <= '0;
      root_r       <= '0;
      minor_r      <= 1'b0;
      neq_r        <= 1'b0;
      guess_root_r <= '0;
      guess_mode_r <= MODE_UNKNOWN;
      out_valid_r  <= 1'b0;
      out_upd_r    <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      bit_r        <= bit_nxt;
      step_r       <= step_nxt;
      root_r       <= root_nxt;
      minor_r      <= minor_nxt;
      neq_r        <= neq_nxt;
      guess_root_r <= guess_root_nxt;
      guess_mode_r <= guess_mode_nxt;
      out_valid_r  <= out_valid_nxt;
      out_upd_r    <= out_upd_nxt;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    cand_root_r <= cand_root_nxt;
    cand_mode_r <= cand_mode_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_updated    = out_upd_r;
  assign out_root_class = guess_root_r;
  assign out_key_mode   = guess_mode_r;

endmodule
